[sv/tga_rle_pixel_decoder_macros.svh]
// ----------------------------------------------------------------------------
// tga rle pixel decoder assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define TGARLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tgarle assertion failed");
`define TGARLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tgarle assertion failed");
`else
`define TGARLE_ASSERT(lbl, clk, rstn, prop)
`define TGARLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// shared types, register codes and colour tables of the tga rle decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned CFG_ADDR_BITS  = 5;
  localparam int unsigned CFG_DATA_BITS  = 32;

  typedef enum logic [2:0] {
    REG_PIXEL_MODE    = 3'd0,
    REG_RLE_ENABLED   = 3'd1,
    REG_FRAME_WIDTH   = 3'd2,
    REG_FRAME_HEIGHT  = 3'd3,
    REG_MIRROR_X      = 3'd4,
    REG_ROWS_TOP_DOWN = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_GRAY8  = 2'd0,
    MODE_RGB555 = 2'd1,
    MODE_BGR24  = 2'd2,
    MODE_BGRA32 = 2'd3
  } pixel_mode_e;

  typedef struct packed {
    pixel_mode_e pixel_mode;
    logic        rle_enabled;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        mirror_x;
    logic        rows_top_down;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] color_index;
  } color_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  repeat_count;
    color_t      color;
    logic        image_done;
  } span_t;

  // floor(v * 255 / 31) for a five-bit channel
  localparam logic [7:0] SCALE5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

`default_nettype wire

[sv/tgarle_if.sv]
// ----------------------------------------------------------------------------
// tgarle channel interfaces
// byte stream in and decoded span out, valid/ready transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tgarle_span_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  repeat_count;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  color_index;
  logic        image_done;

  modport source (
    output valid, output pixel_x, output pixel_y, output repeat_count,
    output red, output green, output blue, output alpha, output color_index,
    output image_done, input ready
  );
  modport sink (
    input valid, input pixel_x, input pixel_y, input repeat_count,
    input red, input green, input blue, input alpha, input color_index,
    input image_done, output ready
  );
endinterface

`default_nettype wire

[sv/tgarle_cfg.sv]
// ----------------------------------------------------------------------------
// tgarle_cfg
// apb register file holding the decoder configuration
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tgarle_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [tgarle_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [tgarle_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                      pready,
  output tgarle_pkg::cfg_t                          cfg_o
);
  import tgarle_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PIXEL_MODE:    cfg_d.pixel_mode    = pixel_mode_e'(pwdata[1:0]);
        REG_RLE_ENABLED:   cfg_d.rle_enabled   = pwdata[0];
        REG_FRAME_WIDTH:   cfg_d.frame_width   = pwdata[15:0];
        REG_FRAME_HEIGHT:  cfg_d.frame_height  = pwdata[15:0];
        REG_MIRROR_X:      cfg_d.mirror_x      = pwdata[0];
        REG_ROWS_TOP_DOWN: cfg_d.rows_top_down = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PIXEL_MODE:    prdata = CFG_DATA_BITS'(cfg_q.pixel_mode);
      REG_RLE_ENABLED:   prdata = CFG_DATA_BITS'(cfg_q.rle_enabled);
      REG_FRAME_WIDTH:   prdata = CFG_DATA_BITS'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:  prdata = CFG_DATA_BITS'(cfg_q.frame_height);
      REG_MIRROR_X:      prdata = CFG_DATA_BITS'(cfg_q.mirror_x);
      REG_ROWS_TOP_DOWN: prdata = CFG_DATA_BITS'(cfg_q.rows_top_down);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode    <= MODE_BGR24;
      cfg_q.rle_enabled   <= 1'b0;
      cfg_q.frame_width   <= 16'd1;
      cfg_q.frame_height  <= 16'd1;
      cfg_q.mirror_x      <= 1'b0;
      cfg_q.rows_top_down <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[sv/tgarle_color.sv]
// ----------------------------------------------------------------------------
// tgarle_color
// expands an assembled pixel word to eight-bit rgba and palette index
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_color (
  input  tgarle_pkg::pixel_mode_e mode_i,
  input  wire logic [31:0]        pix_i,
  output tgarle_pkg::color_t      color_o
);
  import tgarle_pkg::*;

  always_comb begin
    color_o.alpha       = ALPHA_OPAQUE;
    color_o.color_index = 8'd0;
    unique case (mode_i)
      MODE_GRAY8: begin
        color_o.red         = pix_i[7:0];
        color_o.green       = pix_i[7:0];
        color_o.blue        = pix_i[7:0];
        color_o.color_index = pix_i[7:0];
      end
      MODE_RGB555: begin
        // bit 15 is dropped
        color_o.red   = SCALE5[pix_i[14:10]];
        color_o.green = SCALE5[pix_i[9:5]];
        color_o.blue  = SCALE5[pix_i[4:0]];
      end
      MODE_BGR24: begin
        color_o.blue  = pix_i[7:0];
        color_o.green = pix_i[15:8];
        color_o.red   = pix_i[23:16];
      end
      default: begin
        color_o.blue  = pix_i[7:0];
        color_o.green = pix_i[15:8];
        color_o.red   = pix_i[23:16];
        color_o.alpha = pix_i[31:24];
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/tgarle_core.sv]
// ----------------------------------------------------------------------------
// tgarle_core
// input byte register, packet and pixel state update, span result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

module tgarle_core #(
  parameter int unsigned COORD_BITS = tgarle_pkg::COORD_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  tgarle_pkg::cfg_t cfg_i,
  tgarle_byte_if.sink      byte_i,
  tgarle_span_if.source    span_o
);
  import tgarle_pkg::*;

  localparam int unsigned CW = COORD_BITS;

  // input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // decoder state
  logic          expect_q, expect_d;
  logic [7:0]    left_q, left_d;
  logic          is_run_q, is_run_d;
  logic [1:0]    bip_q, bip_d;
  logic [23:0]   pb_q, pb_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic          finished_q, finished_d;

  // result stage
  logic  res_valid_q;
  span_t res_q;

  logic [CW-1:0] w, h, room, x_c, y_c;
  logic [7:0]    n_raw, n_out;
  logic [31:0]   pix;
  logic          active, emit, done, pkt_end;
  color_t        color;

  assign w = (cfg_i.frame_width[CW-1:0] == '0) ? CW'(1) : cfg_i.frame_width[CW-1:0];
  assign h = (cfg_i.frame_height[CW-1:0] == '0) ? CW'(1) : cfg_i.frame_height[CW-1:0];

  assign advance      = in_valid_q && (!res_valid_q || span_o.ready);
  assign byte_i.ready = !in_valid_q || advance;
  assign active       = !finished_q && (row_q < h);

  tgarle_color u_color (
    .mode_i  (cfg_i.pixel_mode),
    .pix_i   (pix),
    .color_o (color)
  );

  always_comb begin
    expect_d   = expect_q;
    left_d     = left_q;
    is_run_d   = is_run_q;
    bip_d      = bip_q;
    pb_d       = pb_q;
    col_d      = col_q;
    row_d      = row_q;
    finished_d = finished_q;
    pix        = {8'd0, pb_q} | (32'(in_byte_q) << {bip_q, 3'b000});
    emit       = 1'b0;
    done       = 1'b0;
    pkt_end    = 1'b1;
    x_c        = '0;
    y_c        = '0;
    room       = w - col_q;
    n_raw      = 8'd1;
    if (cfg_i.rle_enabled && is_run_q && (left_q != 8'd0)) begin
      n_raw = left_q;
    end
    n_out = n_raw;
    if (advance && active) begin
      if (cfg_i.rle_enabled && expect_q) begin
        // packet header
        is_run_d = in_byte_q[7];
        left_d   = {1'b0, in_byte_q[6:0]} + 8'd1;
        expect_d = 1'b0;
        bip_d    = 2'd0;
        pb_d     = '0;
      end else if (bip_q < cfg_i.pixel_mode) begin
        pb_d  = pb_q | (24'(in_byte_q) << {bip_q, 3'b000});
        bip_d = bip_q + 2'd1;
      end else begin
        bip_d = 2'd0;
        pb_d  = '0;
        emit  = col_q < w;
        if (emit) begin
          if (CW'(n_raw) > room) begin
            n_out = room[7:0];
          end
          x_c   = cfg_i.mirror_x ? (w - CW'(1) - col_q) : col_q;
          y_c   = cfg_i.rows_top_down ? row_q : (h - CW'(1) - row_q);
          col_d = col_q + CW'(n_out);
          if ((col_d >= w) && ((row_q + CW'(1)) >= h)) begin
            done       = 1'b1;
            finished_d = 1'b1;
          end
        end
        if (cfg_i.rle_enabled) begin
          if (is_run_q || (left_q <= 8'd1)) begin
            left_d = 8'd0;
          end else begin
            left_d = left_q - 8'd1;
          end
          pkt_end = (left_d == 8'd0);
          if (pkt_end) begin
            expect_d = 1'b1;
          end
        end
        // row advance once the packet closes past the row end
        if (pkt_end && (col_d >= w) && !finished_d) begin
          col_d = '0;
          row_d = row_q + CW'(1);
          if (row_d >= h) begin
            finished_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      expect_q    <= 1'b1;
      left_q      <= 8'd0;
      is_run_q    <= 1'b0;
      bip_q       <= 2'd0;
      pb_q        <= '0;
      col_q       <= '0;
      row_q       <= '0;
      finished_q  <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (advance) begin
        res_valid_q <= emit;
      end else if (span_o.ready) begin
        res_valid_q <= 1'b0;
      end
      expect_q   <= expect_d;
      left_q     <= left_d;
      is_run_q   <= is_run_d;
      bip_q      <= bip_d;
      pb_q       <= pb_d;
      col_q      <= col_d;
      row_q      <= row_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.data_byte;
    end
    if (advance) begin
      res_q.pixel_x      <= 16'(x_c);
      res_q.pixel_y      <= 16'(y_c);
      res_q.repeat_count <= n_out;
      res_q.color        <= color;
      res_q.image_done   <= done;
    end
  end

  assign span_o.valid        = res_valid_q;
  assign span_o.pixel_x      = res_q.pixel_x;
  assign span_o.pixel_y      = res_q.pixel_y;
  assign span_o.repeat_count = res_q.repeat_count;
  assign span_o.red          = res_q.color.red;
  assign span_o.green        = res_q.color.green;
  assign span_o.blue         = res_q.color.blue;
  assign span_o.alpha        = res_q.color.alpha;
  assign span_o.color_index  = res_q.color.color_index;
  assign span_o.image_done   = res_q.image_done;

  `TGARLE_ASSERT(a_count_nonzero, clk_i, rst_ni, res_valid_q |-> (res_q.repeat_count != 8'd0))
  `TGARLE_ASSERT(a_done_finished, clk_i, rst_ni, (res_valid_q && res_q.image_done) |-> finished_q)
  `TGARLE_ASSERT(a_open_packet, clk_i, rst_ni, !expect_q |-> (left_q != 8'd0))
  `TGARLE_ASSERT_NEXT(a_finished_sticky, clk_i, rst_ni, finished_q, finished_q)

endmodule

`default_nettype wire

[sv/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// path: the byte that completes a pixel goes through the input byte register
//   and then the span result register before its span is valid
// throughput: one byte per cycle while the span output is not stalled
// reset: asynchronous, clears configuration to defaults and the packet,
//   pixel, column and row state; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder #(
  parameter int unsigned COORD_BITS = tgarle_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tgarle_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [tgarle_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [tgarle_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                      pready,
  tgarle_byte_if.sink                               byte_i,
  tgarle_span_if.source                             span_o
);
  import tgarle_pkg::*;

  cfg_t cfg;

  tgarle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tgarle_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .byte_i (byte_i),
    .span_o (span_o)
  );

endmodule

`default_nettype wire
